// ===== design/rational_arithmetic_unit_top_macros.svh =====
// Assertion macros for the rational arithmetic unit top level.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RAU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rau_pkg.sv =====
// Package with shared constants, codes and types of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    localparam int DEFAULT_WIDTH = 32;
    localparam int FIELD_WIDTH   = 32;
    localparam int FUNC_WIDTH    = 3;

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_LOAD = 3'd0,
        FUNC_ADD  = 3'd1,
        FUNC_SUB  = 3'd2,
        FUNC_MUL  = 3'd3,
        FUNC_DIV  = 3'd4
    } func_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage
`default_nettype wire

// ===== design/rau_mul.sv =====
// Bit-serial shift-add multiplier that returns the low WIDTH bits of a product.
`default_nettype none
module rau_mul #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [WIDTH-1:0]   product,
    output rau_pkg::unit_stat_t stat
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] mcand_reg;
    logic [WIDTH-1:0] mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(WIDTH);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= a;
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ===== design/rau_div.sv =====
// Restoring divider giving the truncating signed quotient and remainder.
`default_nettype none
module rau_div #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   dividend,
    input  logic [WIDTH-1:0]   divisor,
    output logic [WIDTH-1:0]   quotient,
    output logic [WIDTH-1:0]   remainder,
    output rau_pkg::unit_stat_t stat
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH:0]   rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] divb_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;

    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        mag_a   = dividend[WIDTH-1] ? (-dividend) : dividend;
        mag_b   = divisor[WIDTH-1] ? (-divisor) : divisor;
        shifted = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
        trial   = shifted - {1'b0, divb_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(WIDTH);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= mag_a;
            divb_reg  <= mag_b;
            neg_q_reg <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
            neg_r_reg <= dividend[WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign quotient  = neg_q_reg ? (-quo_reg) : quo_reg;
    assign remainder = neg_r_reg ? (-rem_reg[WIDTH-1:0]) : rem_reg[WIDTH-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ===== design/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit: sequencer, held fraction and result register.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  func, operand_numerator, operand_denominator
//  output   out        out_valid/out_stall  result_numerator, result_denominator, error
//
// Load and unused codes go from idle straight to the output step; an arithmetic item runs
// two products on the bit-serial multiplier (three for add and subtract, one if the new
// denominator is zero), then Euclid's loop and two quotients on the restoring divider.
// Reset leaves the held fraction at 0/1 with no result pending.
// A new item is taken while a finished result waits; a stalled output holds
// the sequencer at its last step until the result register is free.
`default_nettype none
`include "rational_arithmetic_unit_top_macros.svh"
module rational_arithmetic_unit_top #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rau_pkg::FUNC_WIDTH-1:0]    func,
    input  logic signed [rau_pkg::FIELD_WIDTH-1:0] operand_numerator,
    input  logic signed [rau_pkg::FIELD_WIDTH-1:0] operand_denominator,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rau_pkg::FIELD_WIDTH-1:0] result_numerator,
    output logic signed [rau_pkg::FIELD_WIDTH-1:0] result_denominator,
    output logic                              error
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1,
        S_P2,
        S_P3,
        S_GSTART,
        S_GCD,
        S_QN,
        S_QD,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic                   err_reg;
    logic [WIDTH-1:0]       held_n_reg;
    logic [WIDTH-1:0]       held_d_reg;
    logic                   out_valid_reg;
    logic                   mul_start_reg;
    logic                   div_start_reg;

    logic [FUNC_WIDTH-1:0]  func_reg;
    logic [WIDTH-1:0]       s_reg;
    logic [WIDTH-1:0]       i_reg;
    logic [WIDTH-1:0]       nn_reg;
    logic [WIDTH-1:0]       nd_reg;
    logic [WIDTH-1:0]       gb_reg;
    logic [WIDTH-1:0]       mul_a_reg;
    logic [WIDTH-1:0]       mul_b_reg;
    logic [WIDTH-1:0]       div_a_reg;
    logic [WIDTH-1:0]       div_b_reg;
    logic [FIELD_WIDTH-1:0] out_n_reg;
    logic [FIELD_WIDTH-1:0] out_d_reg;
    logic                   out_err_reg;

    logic [WIDTH-1:0]       s_in;
    logic [WIDTH-1:0]       i_in;
    logic [FIELD_WIDTH-1:0] held_n_ext;
    logic [FIELD_WIDTH-1:0] held_d_ext;
    logic [WIDTH-1:0]       product;
    logic [WIDTH-1:0]       quotient;
    logic [WIDTH-1:0]       remainder;
    unit_stat_t             mul_stat;
    unit_stat_t             div_stat;
    logic                   accept;
    logic                   out_free;
    logic                   add_sub;

    if (WIDTH <= FIELD_WIDTH)
    begin : g_in_narrow
        assign s_in = operand_numerator[WIDTH-1:0];
        assign i_in = operand_denominator[WIDTH-1:0];
    end
    else
    begin : g_in_wide
        assign s_in = {{(WIDTH-FIELD_WIDTH){operand_numerator[FIELD_WIDTH-1]}},
                       operand_numerator};
        assign i_in = {{(WIDTH-FIELD_WIDTH){operand_denominator[FIELD_WIDTH-1]}},
                       operand_denominator};
    end

    if (WIDTH >= FIELD_WIDTH)
    begin : g_out_wide
        assign held_n_ext = held_n_reg[FIELD_WIDTH-1:0];
        assign held_d_ext = held_d_reg[FIELD_WIDTH-1:0];
    end
    else
    begin : g_out_narrow
        assign held_n_ext = {{(FIELD_WIDTH-WIDTH){held_n_reg[WIDTH-1]}}, held_n_reg};
        assign held_d_ext = {{(FIELD_WIDTH-WIDTH){held_d_reg[WIDTH-1]}}, held_d_reg};
    end

    rau_mul #(
        .WIDTH(WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .product (product),
        .stat    (mul_stat)
    );

    rau_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign add_sub  = (func_reg == FUNC_ADD) || (func_reg == FUNC_SUB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= 1'b0;
            held_n_reg    <= '0;
            held_d_reg    <= WIDTH'(1);
            out_valid_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        err_reg <= 1'b0;
                        if (func == FUNC_LOAD)
                        begin
                            if (i_in == '0)
                            begin
                                err_reg <= 1'b1;
                            end
                            else
                            begin
                                held_n_reg <= s_in;
                                held_d_reg <= i_in;
                            end
                            state_reg <= S_OUT;
                        end
                        else if (func > FUNC_DIV)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_P1;
                        end
                    end
                end
                S_P1:
                begin
                    if (mul_stat.done)
                    begin
                        if (product == '0)
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_P2;
                        end
                    end
                end
                S_P2:
                begin
                    if (mul_stat.done)
                    begin
                        if (add_sub)
                        begin
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_P3;
                        end
                        else
                        begin
                            state_reg <= S_GSTART;
                        end
                    end
                end
                S_P3:
                begin
                    if (mul_stat.done)
                    begin
                        state_reg <= S_GSTART;
                    end
                end
                S_GSTART:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= S_GCD;
                end
                S_GCD:
                begin
                    if (div_stat.done)
                    begin
                        div_start_reg <= 1'b1;
                        if (remainder == '0)
                        begin
                            state_reg <= S_QN;
                        end
                    end
                end
                S_QN:
                begin
                    if (div_stat.done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_QD;
                    end
                end
                S_QD:
                begin
                    if (div_stat.done)
                    begin
                        held_n_reg <= nn_reg;
                        held_d_reg <= quotient;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_reg  <= func;
                    s_reg     <= s_in;
                    i_reg     <= i_in;
                    mul_a_reg <= held_d_reg;
                    mul_b_reg <= (func == FUNC_DIV) ? s_in : i_in;
                end
            end
            S_P1:
            begin
                if (mul_stat.done)
                begin
                    nd_reg    <= product;
                    mul_a_reg <= held_n_reg;
                    mul_b_reg <= (func_reg == FUNC_MUL) ? s_reg : i_reg;
                end
            end
            S_P2:
            begin
                if (mul_stat.done)
                begin
                    nn_reg    <= product;
                    mul_a_reg <= s_reg;
                    mul_b_reg <= held_d_reg;
                end
            end
            S_P3:
            begin
                if (mul_stat.done)
                begin
                    nn_reg <= (func_reg == FUNC_ADD) ? (nn_reg + product) : (nn_reg - product);
                end
            end
            S_GSTART:
            begin
                div_a_reg <= nn_reg;
                div_b_reg <= nd_reg;
                gb_reg    <= nd_reg;
            end
            S_GCD:
            begin
                if (div_stat.done)
                begin
                    if (remainder == '0)
                    begin
                        div_a_reg <= nn_reg;
                        div_b_reg <= gb_reg;
                    end
                    else
                    begin
                        div_a_reg <= gb_reg;
                        div_b_reg <= remainder;
                        gb_reg    <= remainder;
                    end
                end
            end
            S_QN:
            begin
                if (div_stat.done)
                begin
                    nn_reg    <= quotient;
                    div_a_reg <= nd_reg;
                    div_b_reg <= gb_reg;
                end
            end
            S_QD:
            begin
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_n_reg   <= held_n_ext;
                    out_d_reg   <= held_d_ext;
                    out_err_reg <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid          = out_valid_reg;
    assign result_numerator   = out_n_reg;
    assign result_denominator = out_d_reg;
    assign error              = out_err_reg;

    `RAU_ASSERT_SAME(a_held_den_nonzero, 1'b1, held_d_reg != '0,
        "held denominator became zero")
    `RAU_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE,
        "accepted item did not start the sequencer")
    `RAU_ASSERT_SAME(a_mul_done_state, mul_stat.done,
        state_reg == S_P1 || state_reg == S_P2 || state_reg == S_P3,
        "multiplier finished outside a product step")
    `RAU_ASSERT_SAME(a_mul_start_idle, mul_start_reg, !mul_stat.busy,
        "multiplier started while busy")
    `RAU_ASSERT_SAME(a_div_start_idle, div_start_reg, !div_stat.busy,
        "divider started while busy")

endmodule
`default_nettype wire
